// ----- hw/rtl/hpt_pkg.sv -----
// Package with shared constants and types of the homography point transform.
`default_nettype none

package hpt_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int NUM_REGS       = 8;
    localparam int REG_IDX_W      = 3;
    localparam int CFG_W          = 32;
    localparam int OUT_W          = 32;
    localparam int FRAC_SHIFT     = 22;
    localparam int OVF_SHIFT      = OUT_W - FRAC_SHIFT;
    // Cycles from an accepted start to the done strobe.
    localparam int PIPE_LAT       = 6 + OUT_W;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_M_XX = 3'd0,
        REG_M_XY = 3'd1,
        REG_M_XT = 3'd2,
        REG_M_YX = 3'd3,
        REG_M_YY = 3'd4,
        REG_M_YT = 3'd5,
        REG_M_PX = 3'd6,
        REG_M_PY = 3'd7
    } reg_idx_t;

    localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
        32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0
    };

    localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

`default_nettype wire

// ----- hw/rtl/homography_point_transform.sv -----
// Top level of the pipelined projective point transform.
// Throughput: one transaction per clock; busy is always low and a new start is
// taken every cycle. The depth is set by the 32 one-bit restoring divider stages.
// The receiver cannot stall, so nothing in the pipe ever waits.
// Reset (rst_n low, asynchronous) empties the pipe and restores the matrix defaults.
`default_nettype none

module homography_point_transform #(
    parameter int COORD_BITS = hpt_pkg::COORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [COORD_BITS-1:0]         src_x,
    input  wire logic [COORD_BITS-1:0]         src_y,
    input  wire logic                          cfg_we,
    input  wire logic [hpt_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [hpt_pkg::CFG_W-1:0]     cfg_data,
    output logic                               done,
    output logic signed [hpt_pkg::OUT_W-1:0]   dst_x,
    output logic signed [hpt_pkg::OUT_W-1:0]   dst_y,
    output logic                               bad_denominator
);
    import hpt_pkg::*;

    // Product of a 32-bit term and a zero-extended coordinate.
    localparam int PROD_W = CFG_W + COORD_BITS + 1;
    // Two products plus a 32-bit offset need one more bit of headroom.
    localparam int NUM_W  = PROD_W + 1;
    // Magnitudes keep the full width so the most negative value still fits.
    localparam int MAG_W  = NUM_W;
    // The remainder must hold the divisor shifted by up to 31 places.
    localparam int DIV_W  = MAG_W + OUT_W;

    localparam logic signed [NUM_W-1:0] ONE_Q30 = NUM_W'(1) << 30;

    typedef struct packed {
        logic nsx;   // sign of the x numerator
        logic nsy;   // sign of the y numerator
        logic negx;  // sign of the x quotient
        logic negy;  // sign of the y quotient
        logic zx;    // x numerator is zero
        logic zy;    // y numerator is zero
        logic dz;    // denominator is zero
        logic ovx;   // x quotient is at least 2^32
        logic ovy;   // y quotient is at least 2^32
    } ctl_t;

    // The block never refuses a transaction.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Matrix registers. Write them only while the pipe is empty; the block
    // does not enforce this. The stages below read them directly.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    logic signed [CFG_W-1:0] m_xx, m_xy, m_xt, m_yx, m_yy, m_yt, m_px, m_py;
    assign m_xx = $signed(cfg_reg[REG_M_XX]);
    assign m_xy = $signed(cfg_reg[REG_M_XY]);
    assign m_xt = $signed(cfg_reg[REG_M_XT]);
    assign m_yx = $signed(cfg_reg[REG_M_YX]);
    assign m_yy = $signed(cfg_reg[REG_M_YY]);
    assign m_yt = $signed(cfg_reg[REG_M_YT]);
    assign m_px = $signed(cfg_reg[REG_M_PX]);
    assign m_py = $signed(cfg_reg[REG_M_PY]);

    // ------------------------------------------------------------------
    // Valid bits for the front stages: input, products, sums, magnitudes.
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start & ~busy;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 0: capture the coordinates.
    logic [COORD_BITS-1:0] x_reg, y_reg;

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            x_reg <= src_x;
            y_reg <= src_y;
        end
    end

    // Stage 1: six products, one multiplier each.
    logic signed [COORD_BITS:0] xs, ys;
    assign xs = $signed({1'b0, x_reg});
    assign ys = $signed({1'b0, y_reg});

    logic signed [PROD_W-1:0] pxx_reg, pxy_reg, pyx_reg, pyy_reg, ppx_reg, ppy_reg;

    always_ff @(posedge clk)
    begin
        pxx_reg <= PROD_W'(m_xx) * PROD_W'(xs);
        pxy_reg <= PROD_W'(m_xy) * PROD_W'(ys);
        pyx_reg <= PROD_W'(m_yx) * PROD_W'(xs);
        pyy_reg <= PROD_W'(m_yy) * PROD_W'(ys);
        ppx_reg <= PROD_W'(m_px) * PROD_W'(xs);
        ppy_reg <= PROD_W'(m_py) * PROD_W'(ys);
    end

    // Stage 2: the homogeneous sums. The denominator carries the implied 1.0.
    logic signed [NUM_W-1:0] nx_reg, ny_reg, dn_reg;

    always_ff @(posedge clk)
    begin
        nx_reg <= NUM_W'(pxx_reg) + NUM_W'(pxy_reg) + NUM_W'(m_xt);
        ny_reg <= NUM_W'(pyx_reg) + NUM_W'(pyy_reg) + NUM_W'(m_yt);
        dn_reg <= NUM_W'(ppx_reg) + NUM_W'(ppy_reg) + ONE_Q30;
    end

    // Stage 3: sign and magnitude split, zero detection.
    logic [MAG_W-1:0] nmx_reg, nmy_reg, dm_reg;
    ctl_t             ctl3_reg;

    always_ff @(posedge clk)
    begin
        nmx_reg       <= nx_reg[NUM_W-1] ? MAG_W'(-nx_reg) : MAG_W'(nx_reg);
        nmy_reg       <= ny_reg[NUM_W-1] ? MAG_W'(-ny_reg) : MAG_W'(ny_reg);
        dm_reg        <= dn_reg[NUM_W-1] ? MAG_W'(-dn_reg) : MAG_W'(dn_reg);
        ctl3_reg.nsx  <= nx_reg[NUM_W-1];
        ctl3_reg.nsy  <= ny_reg[NUM_W-1];
        ctl3_reg.negx <= nx_reg[NUM_W-1] ^ dn_reg[NUM_W-1];
        ctl3_reg.negy <= ny_reg[NUM_W-1] ^ dn_reg[NUM_W-1];
        ctl3_reg.zx   <= (nx_reg == '0);
        ctl3_reg.zy   <= (ny_reg == '0);
        ctl3_reg.dz   <= (dn_reg == '0);
        ctl3_reg.ovx  <= 1'b0;
        ctl3_reg.ovy  <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Divider pipe. Entry 0 is the set-up stage: it checks whether the
    // quotient needs more than 32 bits and loads the scaled numerators.
    // Each later entry settles one quotient bit, most significant first.
    // ------------------------------------------------------------------
    logic             dv_v_reg [OUT_W+1];
    logic [DIV_W-1:0] rx_reg   [OUT_W+1];
    logic [DIV_W-1:0] ry_reg   [OUT_W+1];
    logic [MAG_W-1:0] d_reg    [OUT_W+1];
    logic [OUT_W-1:0] qx_reg   [OUT_W+1];
    logic [OUT_W-1:0] qy_reg   [OUT_W+1];
    ctl_t             ctl_reg  [OUT_W+1];
    ctl_t             ctl0;

    always_comb
    begin
        ctl0     = ctl3_reg;
        // num * 2^22 / den >= 2^32 exactly when num >= den * 2^10.
        ctl0.ovx = ({{OVF_SHIFT{1'b0}}, nmx_reg} >= {dm_reg, {OVF_SHIFT{1'b0}}});
        ctl0.ovy = ({{OVF_SHIFT{1'b0}}, nmy_reg} >= {dm_reg, {OVF_SHIFT{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else
        begin
            dv_v_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg[0]  <= {{OVF_SHIFT{1'b0}}, nmx_reg, {FRAC_SHIFT{1'b0}}};
        ry_reg[0]  <= {{OVF_SHIFT{1'b0}}, nmy_reg, {FRAC_SHIFT{1'b0}}};
        d_reg[0]   <= dm_reg;
        qx_reg[0]  <= '0;
        qy_reg[0]  <= '0;
        ctl_reg[0] <= ctl0;
    end

    for (genvar k = 0; k < OUT_W; k++)
    begin : g_div
        logic [DIV_W-1:0] dsh;
        logic [DIV_W:0]   subx, suby;
        logic             gex, gey;

        assign dsh  = {{OUT_W{1'b0}}, d_reg[k]} << (OUT_W - 1 - k);
        assign subx = {1'b0, rx_reg[k]} - {1'b0, dsh};
        assign suby = {1'b0, ry_reg[k]} - {1'b0, dsh};
        assign gex  = ~subx[DIV_W];
        assign gey  = ~suby[DIV_W];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rx_reg[k+1]  <= gex ? subx[DIV_W-1:0] : rx_reg[k];
            ry_reg[k+1]  <= gey ? suby[DIV_W-1:0] : ry_reg[k];
            qx_reg[k+1]  <= {qx_reg[k][OUT_W-2:0], gex};
            qy_reg[k+1]  <= {qy_reg[k][OUT_W-2:0], gey};
            d_reg[k+1]   <= d_reg[k];
            ctl_reg[k+1] <= ctl_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply signs and saturate. A zero denominator gives 0
    // for a 0 numerator, else its sign; an overflow takes the quotient's.
    // ------------------------------------------------------------------
    ctl_t             cf;
    logic [OUT_W-1:0] qfx, qfy;
    logic             satx, saty, badx, bady;
    logic [OUT_W-1:0] ox, oy;

    assign cf  = ctl_reg[OUT_W];
    assign qfx = qx_reg[OUT_W];
    assign qfy = qy_reg[OUT_W];

    // The negative range reaches one step further than the positive one.
    assign satx = cf.ovx | (cf.negx ? (qfx > SAT_NEG) : qfx[OUT_W-1]);
    assign saty = cf.ovy | (cf.negy ? (qfy > SAT_NEG) : qfy[OUT_W-1]);

    always_comb
    begin
        if (cf.dz)
        begin
            ox = cf.zx ? '0 : (cf.nsx ? SAT_NEG : SAT_POS);
            oy = cf.zy ? '0 : (cf.nsy ? SAT_NEG : SAT_POS);
        end
        else
        begin
            ox = satx ? (cf.negx ? SAT_NEG : SAT_POS) : (cf.negx ? -qfx : qfx);
            oy = saty ? (cf.negy ? SAT_NEG : SAT_POS) : (cf.negy ? -qfy : qfy);
        end
    end

    assign badx = cf.dz | satx;
    assign bady = cf.dz | saty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done            <= 1'b0;
            dst_x           <= '0;
            dst_y           <= '0;
            bad_denominator <= 1'b0;
        end
        else if (dv_v_reg[OUT_W])
        begin
            done            <= 1'b1;
            dst_x           <= $signed(ox);
            dst_y           <= $signed(oy);
            bad_denominator <= badx | bady;
        end
        else
        begin
            done            <= 1'b0;
            dst_x           <= '0;
            dst_y           <= '0;
            bad_denominator <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hpt_checker.sv -----
// Port-level checker for the homography point transform, with its bind.
`default_nettype none

module hpt_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic                               done,
    input wire logic signed [hpt_pkg::OUT_W-1:0]   dst_x,
    input wire logic signed [hpt_pkg::OUT_W-1:0]   dst_y,
    input wire logic                               bad_denominator
);
    import hpt_pkg::*;

    // The pipe never pushes back.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every accepted transaction comes out after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(PIPE_LAT) done)
        else $error("result missing at expected latency");

    // No result without a transaction accepted the fixed latency earlier.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        (!start || busy) |-> ##(PIPE_LAT) !done)
        else $error("result without a transaction");

    // Between results the outputs rest at zero.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (dst_x == '0 && dst_y == '0 && !bad_denominator))
        else $error("outputs active without done");

endmodule

bind homography_point_transform hpt_checker u_hpt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .dst_x           (dst_x),
    .dst_y           (dst_y),
    .bad_denominator (bad_denominator)
);

`default_nettype wire
